[design/gbfp_pkg.sv]
`default_nettype none
package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_CKERR = 3'd3;
  localparam logic [2:0] EV_OVERSIZE = 3'd4;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_type;
    logic [15:0] frame_length;
  } res_t;

endpackage
`default_nettype wire

[design/gbfp_ifs.sv]
`default_nettype none
interface gbfp_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbfp_out_if;
  logic valid;
  logic ready;
  logic [2:0] event_res;
  logic [7:0] payload_byte;
  logic [15:0] payload_index;
  logic [15:0] frame_type;
  logic [15:0] frame_length;
  modport source (output valid, output event_res, output payload_byte, output payload_index,
                  output frame_type, output frame_length, input ready);
  modport sink (input valid, input event_res, input payload_byte, input payload_index,
                input frame_type, input frame_length, output ready);
endinterface

interface gbfp_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] max_payload;
  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface
`default_nettype wire

[design/gbfp_core.sv]
`default_nettype none
module gbfp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [15:0]   max_payload,
  output gbfp_pkg::res_t     res
);

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  phase_t phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [15:0] type_word, type_word_next;
  logic [15:0] length_word, length_word_next;

  phase_t ph_e;
  logic [15:0] bp_e, tw_e, lw_e;
  logic [7:0] sa_add, sb_add, check_sum;
  logic [15:0] bp_inc;
  logic fits;

  always_comb begin
    // Any phase past the checksum starts the byte from a cleared frame.
    unique case (phase)
      PH_SYNC, PH_TYPE, PH_LENGTH, PH_PAYLOAD, PH_CHECK: begin
        ph_e = phase;
        bp_e = byte_position;
        tw_e = type_word;
        lw_e = length_word;
      end
      default: begin
        ph_e = PH_SYNC;
        bp_e = '0;
        tw_e = '0;
        lw_e = '0;
      end
    endcase

    sa_add = sum_a + rx_byte;
    sb_add = sum_b + sa_add;
    check_sum = (bp_e == 16'd0) ? sum_a : sum_b;
    bp_inc = bp_e + 16'd1;
    fits = (lw_e <= max_payload);

    phase_next = ph_e;
    byte_position_next = bp_e;
    sum_a_next = sum_a;
    sum_b_next = sum_b;
    type_word_next = tw_e;
    length_word_next = lw_e;

    res.event_res = gbfp_pkg::EV_NONE;
    res.payload_byte = '0;
    res.payload_index = '0;

    unique case (ph_e)
      PH_SYNC: begin
        if (bp_e == 16'd0) begin
          if (rx_byte == gbfp_pkg::SYNC_FIRST) byte_position_next = 16'd1;
        end else begin
          if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
            sum_a_next = '0;
            sum_b_next = '0;
            phase_next = PH_TYPE;
          end
          byte_position_next = '0;
        end
      end
      PH_TYPE: begin
        if (bp_e == 16'd0) begin
          type_word_next = {8'd0, rx_byte};
          byte_position_next = 16'd1;
        end else begin
          type_word_next = {rx_byte, tw_e[7:0]};
          byte_position_next = '0;
          phase_next = PH_LENGTH;
        end
        sum_a_next = sa_add;
        sum_b_next = sb_add;
      end
      PH_LENGTH: begin
        if (bp_e == 16'd0) begin
          length_word_next = {8'd0, rx_byte};
          byte_position_next = 16'd1;
        end else begin
          length_word_next = {rx_byte, lw_e[7:0]};
          byte_position_next = '0;
          phase_next = ({rx_byte, lw_e[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CHECK;
        end
        sum_a_next = sa_add;
        sum_b_next = sb_add;
      end
      PH_PAYLOAD: begin
        if (fits) begin
          res.event_res = gbfp_pkg::EV_PAYLOAD;
          res.payload_byte = rx_byte;
          res.payload_index = bp_e;
        end
        if (bp_inc == lw_e) begin
          phase_next = PH_CHECK;
          byte_position_next = '0;
        end else begin
          byte_position_next = bp_inc;
        end
        sum_a_next = sa_add;
        sum_b_next = sb_add;
      end
      PH_CHECK: begin
        if (check_sum == rx_byte) begin
          if (bp_e == 16'd0) begin
            byte_position_next = 16'd1;
          end else if (fits) begin
            res.event_res = gbfp_pkg::EV_DONE;
            phase_next = PH_DONE;
            byte_position_next = 16'd2;
          end else begin
            res.event_res = gbfp_pkg::EV_OVERSIZE;
            phase_next = PH_SYNC;
            byte_position_next = '0;
            type_word_next = '0;
            length_word_next = '0;
          end
        end else begin
          res.event_res = gbfp_pkg::EV_CKERR;
          phase_next = PH_SYNC;
          byte_position_next = '0;
          type_word_next = '0;
          length_word_next = '0;
        end
      end
      default: begin
        phase_next = ph_e;
      end
    endcase

    // End-of-frame results report the frame as it was before any clearing.
    if (ph_e == PH_CHECK) begin
      res.frame_type = tw_e;
      res.frame_length = lw_e;
    end else begin
      res.frame_type = type_word_next;
      res.frame_length = length_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      byte_position <= '0;
      sum_a <= '0;
      sum_b <= '0;
      type_word <= '0;
      length_word <= '0;
    end else if (step) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
      type_word <= type_word_next;
      length_word <= length_word_next;
    end
  end

endmodule
`default_nettype wire

[design/gnss_binary_frame_parser.sv]
`default_nettype none
// Channel  Dir  Payload                                   Beat
// rx       in   rx_byte                                   one received byte
// res      out  event_res, payload_byte, payload_index,   one result per byte
//               frame_type, frame_length
// cfg      in   max_payload                               one register write
//
// Each byte is captured in an input register, decoded combinationally and lands
// in the result register, so one byte per cycle flows through while the result
// is not stalled. The parser state advances when a byte moves into the result
// register. A stalled result holds the result register and the input
// register; the input register frees as soon as its byte moves on.
// Reset returns the parser to the sync hunt and max_payload to 256.
module gnss_binary_frame_parser (
  input wire logic  clk,
  input wire logic  rst,
  gbfp_in_if.sink   rx,
  gbfp_out_if.source res,
  gbfp_cfg_if.sink  cfg
);

  logic in_valid;
  logic [7:0] in_byte;
  logic out_valid;
  gbfp_pkg::res_t out_res;
  gbfp_pkg::res_t core_res;
  logic [15:0] max_payload;
  logic move;

  assign move = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || move;
  assign cfg.ready = 1'b1;

  gbfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .rx_byte     (in_byte),
    .max_payload (max_payload),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      max_payload <= gbfp_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (cfg.valid) max_payload <= cfg.max_payload;
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
        in_byte <= rx.rx_byte;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
        out_res <= core_res;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid = out_valid;
  assign res.event_res = out_res.event_res;
  assign res.payload_byte = out_res.payload_byte;
  assign res.payload_index = out_res.payload_index;
  assign res.frame_type = out_res.frame_type;
  assign res.frame_length = out_res.frame_length;

endmodule
`default_nettype wire
